@@ hw/rtl/slt_pkg.sv @@
package slt_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int KEY_WIDTH   = 16;
   localparam int LABEL_WIDTH = 16;

   // entry count holds 0..TABLE_DEPTH
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // two-level match tree: cells in groups, then the groups
   localparam int GROUP_SIZE = 64;
   localparam int NUM_GROUPS = (TABLE_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_PRESENT = 2'd1;
   localparam logic [1:0] STAT_FULL    = 2'd2;

   // broadcast to every cell of the row
   typedef struct packed {
      logic                   cmp_en;
      logic                   ins_en;
      logic [KEY_WIDTH-1:0]   key;
      logic [LABEL_WIDTH-1:0] label;
   } slt_ctl_type;

endpackage

@@ hw/rtl/slt_cell.sv @@
module slt_cell import slt_pkg::*; (
   input  logic                   clock,
   input  slt_ctl_type            ctl,
   input  logic                   valid,
   input  logic                   prev_lt,
   input  logic [KEY_WIDTH-1:0]   prev_key,
   input  logic [LABEL_WIDTH-1:0] prev_label,
   output logic                   lt_ff,
   output logic                   eq_ff,
   output logic [KEY_WIDTH-1:0]   key_ff,
   output logic [LABEL_WIDTH-1:0] label_ff
);

   logic                   lt_in;
   logic                   eq_in;
   logic [KEY_WIDTH-1:0]   key_in;
   logic [LABEL_WIDTH-1:0] label_in;

   assign lt_in = valid && (key_ff < ctl.key);
   assign eq_in = valid && (key_ff == ctl.key);

   // first cell not below the new key takes it, the ones above shift up by one
   assign key_in   = prev_lt ? ctl.key   : prev_key;
   assign label_in = prev_lt ? ctl.label : prev_label;

   always_ff @(posedge clock) begin
      if (ctl.cmp_en) begin
         lt_ff <= lt_in;
         eq_ff <= eq_in;
      end
      if (ctl.ins_en && !lt_ff) begin
         key_ff   <= key_in;
         label_ff <= label_in;
      end
   end

endmodule

@@ hw/rtl/slt_reduce.sv @@
module slt_reduce import slt_pkg::*; (
   input  logic                   clock,
   input  logic                   en,
   input  logic [GROUP_SIZE-1:0]  hit_in,
   input  logic [LABEL_WIDTH-1:0] label_in [GROUP_SIZE],
   output logic                   hit_ff,
   output logic [LABEL_WIDTH-1:0] label_ff
);

   logic [LABEL_WIDTH-1:0] label_or;

   // keys are unique, so at most one input hits and an OR selects it
   always_comb begin
      label_or = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
         label_or = label_or | (label_in[j] & {LABEL_WIDTH{hit_in[j]}});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff   <= |hit_in;
         label_ff <= label_or;
      end
   end

endmodule

@@ hw/rtl/sorted_label_table_unit.sv @@
// Flow: an accepted request passes compare, group match, final match and
// commit, then the result is registered. Only one request is in flight:
// req_stall holds off any further request until the last one commits.
// Reset: entry count and label counter cleared; table contents undefined,
// no clearing pass. A waiting result holds while rsp_stall is high.
module sorted_label_table_unit import slt_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_op,
   input  logic [KEY_WIDTH-1:0]   req_key,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_status,
   output logic                   rsp_found,
   output logic [LABEL_WIDTH-1:0] rsp_label_number
);

   typedef enum logic [2:0] {S_IDLE, S_CMP, S_RED1, S_RED2, S_DONE} state_type;

   state_type              state_ff;
   logic [1:0]             op_ff;
   logic [KEY_WIDTH-1:0]   key_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [LABEL_WIDTH-1:0] next_label_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff;
   logic                   rsp_found_ff;
   logic [LABEL_WIDTH-1:0] rsp_label_ff;

   logic                   rsp_valid_in;
   logic [1:0]             rsp_status_in;
   logic                   rsp_found_in;
   logic [LABEL_WIDTH-1:0] rsp_label_in;

   slt_ctl_type            ctl;
   logic                   finish;
   logic                   full;
   logic                   do_insert;
   logic [LABEL_WIDTH-1:0] label_next;

   logic [KEY_WIDTH-1:0]   cell_key   [TABLE_DEPTH];
   logic [LABEL_WIDTH-1:0] cell_label [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] cell_lt;
   logic [TABLE_DEPTH-1:0] cell_eq;

   logic [GROUP_SIZE-1:0]  grp_hit;
   logic [LABEL_WIDTH-1:0] grp_label [GROUP_SIZE];
   logic                   hit_ff;
   logic [LABEL_WIDTH-1:0] hit_label_ff;

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_label_number = rsp_label_ff;

   assign finish     = (state_ff == S_DONE) && !(rsp_valid_ff && rsp_stall);
   assign full       = (count_ff == CNT_W'(TABLE_DEPTH));
   assign label_next = next_label_ff + LABEL_WIDTH'(1);
   assign do_insert  = finish && (op_ff == OP_INSERT) && !hit_ff && !full;

   // hold a stalled result, raise a new one when the request commits
   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_comb begin
      ctl.cmp_en = (state_ff == S_CMP);
      ctl.ins_en = do_insert;
      ctl.key    = key_ff;
      ctl.label  = label_next;
   end

   always_comb begin
      rsp_status_in = STAT_DONE;
      rsp_found_in  = 1'b0;
      rsp_label_in  = '0;
      unique case (op_ff)
         OP_CLEAR: begin
         end
         OP_INSERT: begin
            if (hit_ff) begin
               rsp_status_in = STAT_PRESENT;
               rsp_found_in  = 1'b1;
               rsp_label_in  = hit_label_ff;
            end else if (full) begin
               rsp_status_in = STAT_FULL;
            end else begin
               rsp_found_in  = 1'b1;
               rsp_label_in  = label_next;
            end
         end
         OP_LOOKUP: begin
            if (hit_ff) begin
               rsp_found_in = 1'b1;
               rsp_label_in = hit_label_ff;
            end
         end
         default: begin
            // unused code: plain done, no change
         end
      endcase
   end

   genvar i, g, j;
   generate
      for (i = 0; i < TABLE_DEPTH; i++) begin : g_cell
         logic                   prev_lt;
         logic [KEY_WIDTH-1:0]   prev_key;
         logic [LABEL_WIDTH-1:0] prev_label;
         if (i == 0) begin : g_head
            assign prev_lt    = 1'b1;
            assign prev_key   = '0;
            assign prev_label = '0;
         end else begin : g_link
            assign prev_lt    = cell_lt[i-1];
            assign prev_key   = cell_key[i-1];
            assign prev_label = cell_label[i-1];
         end
         slt_cell u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .valid      (CNT_W'(i) < count_ff),
            .prev_lt    (prev_lt),
            .prev_key   (prev_key),
            .prev_label (prev_label),
            .lt_ff      (cell_lt[i]),
            .eq_ff      (cell_eq[i]),
            .key_ff     (cell_key[i]),
            .label_ff   (cell_label[i])
         );
      end

      for (g = 0; g < GROUP_SIZE; g++) begin : g_group
         if (g < NUM_GROUPS) begin : g_used
            logic [GROUP_SIZE-1:0]  hit_in;
            logic [LABEL_WIDTH-1:0] label_in [GROUP_SIZE];
            for (j = 0; j < GROUP_SIZE; j++) begin : g_tap
               if (g * GROUP_SIZE + j < TABLE_DEPTH) begin : g_real
                  assign hit_in[j]   = cell_eq[g * GROUP_SIZE + j];
                  assign label_in[j] = cell_label[g * GROUP_SIZE + j];
               end else begin : g_pad
                  assign hit_in[j]   = 1'b0;
                  assign label_in[j] = '0;
               end
            end
            slt_reduce u_grp (
               .clock    (clock),
               .en       (state_ff == S_RED1),
               .hit_in   (hit_in),
               .label_in (label_in),
               .hit_ff   (grp_hit[g]),
               .label_ff (grp_label[g])
            );
         end else begin : g_unused
            assign grp_hit[g]   = 1'b0;
            assign grp_label[g] = '0;
         end
      end
   endgenerate

   slt_reduce u_top (
      .clock    (clock),
      .en       (state_ff == S_RED2),
      .hit_in   (grp_hit),
      .label_in (grp_label),
      .hit_ff   (hit_ff),
      .label_ff (hit_label_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         next_label_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_op;
                  key_ff   <= req_key;
                  state_ff <= S_CMP;
               end
            end
            S_CMP:  state_ff <= S_RED1;
            S_RED1: state_ff <= S_RED2;
            S_RED2: state_ff <= S_DONE;
            S_DONE: begin
               if (finish) begin
                  rsp_status_ff <= rsp_status_in;
                  rsp_found_ff  <= rsp_found_in;
                  rsp_label_ff  <= rsp_label_in;
                  state_ff      <= S_IDLE;
                  if (op_ff == OP_CLEAR) begin
                     count_ff <= '0;
                  end else if (do_insert) begin
                     count_ff      <= count_ff + CNT_W'(1);
                     next_label_ff <= label_next;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ hw/rtl/slt_checker.sv @@
module slt_checker import slt_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_status,
   input logic                   rsp_found,
   input logic [LABEL_WIDTH-1:0] rsp_label_number
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_found) && $stable(rsp_label_number))
      else $error("stalled result changed");

   // one request in flight: an accepted request blocks the next
   a_one_inflight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_label_number == '0)
      else $error("label given without a match");

   a_present_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_PRESENT |-> rsp_found)
      else $error("duplicate reported without match");

   a_full_missing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |-> !rsp_found)
      else $error("full table reported with match");

endmodule

bind sorted_label_table_unit slt_checker u_slt_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_found        (rsp_found),
   .rsp_label_number (rsp_label_number)
);

@@ tb/tb_sorted_label_table_unit.sv @@
import slt_pkg::*;

typedef struct packed {
   logic [1:0]             status;
   logic                   found;
   logic [LABEL_WIDTH-1:0] label_number;
} label_reply_type;

class label_table_scoreboard;
   logic [KEY_WIDTH-1:0]   keys   [TABLE_DEPTH];
   logic [LABEL_WIDTH-1:0] labels [TABLE_DEPTH];
   int unsigned            used;
   logic [LABEL_WIDTH-1:0] last_label;
   label_reply_type        due [$];
   int unsigned            failures;

   function new();
      used       = 0;
      last_label = '0;
      failures   = 0;
   endfunction

   // first slot whose key is not below k
   function int unsigned slot_for(logic [KEY_WIDTH-1:0] k);
      int unsigned lo, hi, mid;
      lo = 0;
      hi = used;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (keys[mid] < k) lo = mid + 1;
         else hi = mid;
      end
      return lo;
   endfunction

   function void note_request(logic [1:0] op, logic [KEY_WIDTH-1:0] k);
      int unsigned     pos;
      int unsigned     i;
      bit              hit;
      label_reply_type r;
      pos = slot_for(k);
      hit = (pos < used) && (keys[pos] == k);
      r.status       = STAT_DONE;
      r.found        = 1'b0;
      r.label_number = '0;
      unique case (op)
         OP_CLEAR: used = 0;
         OP_INSERT: begin
            if (hit) begin
               r.status       = STAT_PRESENT;
               r.found        = 1'b1;
               r.label_number = labels[pos];
            end else if (used >= TABLE_DEPTH) begin
               r.status = STAT_FULL;
            end else begin
               // open a gap at the sorted position
               for (i = used; i > pos; i--) begin
                  keys[i]   = keys[i-1];
                  labels[i] = labels[i-1];
               end
               last_label     = last_label + 1'b1;
               keys[pos]      = k;
               labels[pos]    = last_label;
               used++;
               r.found        = 1'b1;
               r.label_number = last_label;
            end
         end
         OP_LOOKUP: begin
            if (hit) begin
               r.found        = 1'b1;
               r.label_number = labels[pos];
            end
         end
         default: ;
      endcase
      due.push_back(r);
   endfunction

   function void check_response(logic [1:0] status, logic found,
                                logic [LABEL_WIDTH-1:0] label_number);
      label_reply_type want;
      if (due.size() == 0) begin
         failures++;
         if (failures <= 10)
            $display("unexpected result: status %0d found %0d label %0d",
                     status, found, label_number);
         return;
      end
      want = due.pop_front();
      if (status !== want.status || found !== want.found ||
          label_number !== want.label_number) begin
         failures++;
         if (failures <= 10)
            $display("result mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                     want.status, want.found, want.label_number,
                     status, found, label_number);
      end
   endfunction
endclass

module tb_sorted_label_table_unit;
   localparam logic [1:0] OP_UNUSED   = 2'd3;
   localparam int         QUIET_LIMIT = 400;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [1:0]             req_op;
   logic [KEY_WIDTH-1:0]   req_key;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [1:0]             rsp_status;
   logic                   rsp_found;
   logic [LABEL_WIDTH-1:0] rsp_label_number;
   bit                     calm = 1'b0;

   label_table_scoreboard sb = new();

   always #6 clock = ~clock;

   sorted_label_table_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_found        (rsp_found),
      .rsp_label_number (rsp_label_number)
   );

   // hold the request until accepted, then maybe drop valid for a burst
   task automatic send_request(input logic [1:0] op, input logic [KEY_WIDTH-1:0] k);
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= k;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, k);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // stored key, a near neighbour of one, or anything at all
   function automatic logic [KEY_WIDTH-1:0] pick_key();
      int unsigned sel;
      sel = $urandom_range(0, 3);
      if (sb.used != 0 && sel < 2) return sb.keys[$urandom_range(0, sb.used - 1)];
      if (sb.used != 0 && sel == 2)
         return sb.keys[$urandom_range(0, sb.used - 1)] ^ KEY_WIDTH'(1);
      return KEY_WIDTH'($urandom);
   endfunction

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_response(rsp_status, rsp_found, rsp_label_number);
   end

   initial begin
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      int unsigned n, r;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_op    <= OP_CLEAR;
      req_key   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(OP_LOOKUP, 16'h0000);
      send_request(OP_INSERT, 16'h8000);
      send_request(OP_INSERT, 16'h0000);
      send_request(OP_INSERT, 16'hFFFF);
      send_request(OP_INSERT, 16'h0000);
      send_request(OP_LOOKUP, 16'hFFFF);
      send_request(OP_LOOKUP, 16'h0000);
      send_request(OP_LOOKUP, 16'h1234);
      send_request(OP_UNUSED, 16'hFFFF);
      send_request(OP_INSERT, 16'h5555);
      send_request(OP_INSERT, 16'hAAAA);
      send_request(OP_LOOKUP, 16'h5555);
      send_request(OP_INSERT, 16'hAAAA);
      send_request(OP_CLEAR,  16'hFFFF);
      send_request(OP_LOOKUP, 16'h8000);
      // label counter survives the clear
      send_request(OP_INSERT, 16'h8000);
      send_request(OP_UNUSED, 16'h0000);
      send_request(OP_CLEAR,  16'h0000);

      // fill the table to the brim
      while (sb.used < TABLE_DEPTH) begin
         if ($urandom_range(0, 9) != 0) send_request(OP_INSERT, KEY_WIDTH'($urandom));
         else send_request(OP_LOOKUP, pick_key());
      end

      repeat (20) begin
         r = $urandom_range(0, 3);
         unique case (r)
            0: send_request(OP_INSERT, KEY_WIDTH'($urandom));
            1: send_request(OP_INSERT, sb.keys[$urandom_range(0, TABLE_DEPTH - 1)]);
            2: send_request(OP_LOOKUP, pick_key());
            default: send_request(OP_UNUSED, pick_key());
         endcase
      end
      send_request(OP_INSERT, 16'h0000);
      send_request(OP_INSERT, 16'hFFFF);
      send_request(OP_CLEAR, KEY_WIDTH'($urandom));

      // small tables, frequent clears and repeats
      for (n = 0; n < 120; n++) begin
         if (n == 80) calm = 1'b1;
         r = $urandom_range(0, 99);
         if (r < 6) send_request(OP_CLEAR, KEY_WIDTH'($urandom));
         else if (r < 10) send_request(OP_UNUSED, pick_key());
         else if (r < 55) send_request(OP_INSERT, pick_key());
         else send_request(OP_LOOKUP, pick_key());
      end
      req_valid <= 1'b0;

      while (sb.due.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
      if (sb.failures == 0 && sb.due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule

@@ filelist.f @@
hw/rtl/slt_pkg.sv
hw/rtl/slt_cell.sv
hw/rtl/slt_reduce.sv
hw/rtl/sorted_label_table_unit.sv
hw/rtl/slt_checker.sv
tb/tb_sorted_label_table_unit.sv
